@@ rtl/alst_pkg.sv @@
// Shared types and codes of the array list engine.
package alst_pkg;

	typedef enum logic [2:0] {
		REQ_INSERT  = 3'd0,
		REQ_DELETE  = 3'd1,
		REQ_REVERSE = 3'd2,
		REQ_ROTATE  = 3'd3,
		REQ_DEDUP   = 3'd4,
		REQ_READ    = 3'd5
	} req_code_t;

	typedef enum logic [1:0] {
		STS_OK     = 2'd0,
		STS_FULL   = 2'd1,
		STS_BADPOS = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		RP_NONE,
		RP_FIRST,
		RP_SECOND,
		RP_THIRD
	} rot_phase_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_CHECK,
		S_INS_LOOP,
		S_INS_WR,
		S_DEL_LOOP,
		S_DEL_WR,
		S_REV_LOOP,
		S_REV_RDHI,
		S_REV_WRLO,
		S_REV_WRHI,
		S_MOD,
		S_DUP_FIRST,
		S_DUP_LOOP,
		S_DUP_CMP,
		S_READ_WAIT,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [2:0]        req_type;
		logic [31:0]       value;
		logic [4:0]        pos;
		logic [4:0]        pos_end;
		logic signed [5:0] rotate_amount;
	} request_t;

	typedef struct packed {
		logic [31:0] read_value;
		logic [4:0]  list_length;
		logic [1:0]  status;
	} result_t;

endpackage

@@ rtl/alst_ctrl.sv @@
// Sequencer, entry memory and index arithmetic of the array list engine.
module alst_ctrl import alst_pkg::*; #(
	parameter int CAPACITY = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  request_t req,
	output logic     ready,
	output logic     done,
	input  logic     done_ack,
	output result_t  result
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int LW = ((CW > 5) ? CW : 5) + 1;
	localparam int SW = ((CW > 6) ? CW : 6) + 2;

	logic [31:0] mem [CAPACITY];
	logic [31:0] rdata;
	logic        re;
	logic        we;
	logic [AW-1:0] raddr;
	logic [AW-1:0] waddr;
	logic [31:0]   wdata;

	state_t     state_q, state_d;
	rot_phase_t phase_q, phase_d;
	logic [CW-1:0] count_q, count_d;
	logic [CW-1:0] i_q, i_d;
	logic [CW-1:0] w_q, w_d;
	logic [CW-1:0] lo_q, lo_d;
	logic [CW-1:0] hi_q, hi_d;
	logic signed [SW-1:0] s_q, s_d;
	logic [31:0] tmp_q, tmp_d;
	logic [31:0] rdv_q, rdv_d;
	status_t     status_q, status_d;
	request_t    req_q, req_d;

	logic [LW-1:0] pos_ext;
	logic [LW-1:0] pend_ext;
	logic [LW-1:0] cnt_ext;
	logic [LW-1:0] len_ext;
	logic [CW-1:0] i_dec;
	logic [CW-1:0] i_inc;
	logic [CW-1:0] pos_m1;
	logic [CW-1:0] pend_m1;
	logic [CW-1:0] cnt_m1;
	logic signed [SW-1:0] n_s;
	logic [CW-1:0] s_cw;

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			phase_q <= RP_NONE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		i_q      <= i_d;
		w_q      <= w_d;
		lo_q     <= lo_d;
		hi_q     <= hi_d;
		s_q      <= s_d;
		tmp_q    <= tmp_d;
		rdv_q    <= rdv_d;
		status_q <= status_d;
		req_q    <= req_d;
	end

	assign pos_ext  = LW'(req_q.pos);
	assign pend_ext = LW'(req_q.pos_end);
	assign cnt_ext  = LW'(count_q);
	assign len_ext  = LW'(count_q);
	assign i_dec    = i_q - 1'b1;
	assign i_inc    = i_q + 1'b1;
	assign pos_m1   = CW'(pos_ext - 1'b1);
	assign pend_m1  = CW'(pend_ext - 1'b1);
	assign cnt_m1   = count_q - 1'b1;
	assign n_s      = SW'(count_q);
	assign s_cw     = s_q[CW-1:0];

	always_comb begin
		state_d  = state_q;
		phase_d  = phase_q;
		count_d  = count_q;
		i_d      = i_q;
		w_d      = w_q;
		lo_d     = lo_q;
		hi_d     = hi_q;
		s_d      = s_q;
		tmp_d    = tmp_q;
		rdv_d    = rdv_q;
		status_d = status_q;
		req_d    = req_q;
		re       = 1'b0;
		we       = 1'b0;
		raddr    = i_q[AW-1:0];
		waddr    = i_q[AW-1:0];
		wdata    = rdata;
		ready    = 1'b0;
		done     = 1'b0;

		unique case (state_q)
			S_IDLE: begin
				ready = 1'b1;
				if (start) begin
					req_d   = req;
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				rdv_d    = '0;
				status_d = STS_OK;
				phase_d  = RP_NONE;
				state_d  = S_DONE;
				case (req_q.req_type)
					REQ_INSERT: begin
						if (count_q == CW'(CAPACITY)) begin
							status_d = STS_FULL;
						end else if (pos_ext == '0 || pos_ext > cnt_ext + 1'b1) begin
							status_d = STS_BADPOS;
						end else begin
							i_d     = count_q;
							state_d = S_INS_LOOP;
						end
					end
					REQ_DELETE: begin
						if (pos_ext == '0 || pos_ext > cnt_ext) begin
							status_d = STS_BADPOS;
						end else begin
							i_d     = pos_m1;
							state_d = S_DEL_LOOP;
						end
					end
					REQ_REVERSE: begin
						if (pos_ext == '0 || pos_ext > cnt_ext ||
						    pend_ext == '0 || pend_ext > cnt_ext) begin
							status_d = STS_BADPOS;
						end else if (pos_ext < pend_ext) begin
							lo_d    = pos_m1;
							hi_d    = pend_m1;
							state_d = S_REV_LOOP;
						end
					end
					REQ_ROTATE: begin
						if (count_q != '0) begin
							s_d     = SW'(req_q.rotate_amount);
							state_d = S_MOD;
						end
					end
					REQ_DEDUP: begin
						if (count_q > CW'(1)) begin
							re      = 1'b1;
							raddr   = '0;
							state_d = S_DUP_FIRST;
						end
					end
					REQ_READ: begin
						if (pos_ext == '0 || pos_ext > cnt_ext) begin
							status_d = STS_BADPOS;
						end else begin
							re      = 1'b1;
							raddr   = pos_m1[AW-1:0];
							state_d = S_READ_WAIT;
						end
					end
					default: begin
						state_d = S_DONE;
					end
				endcase
			end
			S_INS_LOOP: begin
				if (LW'(i_q) >= pos_ext) begin
					re      = 1'b1;
					raddr   = i_dec[AW-1:0];
					state_d = S_INS_WR;
				end else begin
					we      = 1'b1;
					waddr   = pos_m1[AW-1:0];
					wdata   = req_q.value;
					count_d = count_q + 1'b1;
					state_d = S_DONE;
				end
			end
			S_INS_WR: begin
				we      = 1'b1;
				waddr   = i_q[AW-1:0];
				i_d     = i_dec;
				state_d = S_INS_LOOP;
			end
			S_DEL_LOOP: begin
				if (LW'(i_q) + 1'b1 < cnt_ext) begin
					re      = 1'b1;
					raddr   = i_inc[AW-1:0];
					state_d = S_DEL_WR;
				end else begin
					count_d = cnt_m1;
					state_d = S_DONE;
				end
			end
			S_DEL_WR: begin
				we      = 1'b1;
				waddr   = i_q[AW-1:0];
				i_d     = i_inc;
				state_d = S_DEL_LOOP;
			end
			S_REV_LOOP: begin
				if (lo_q < hi_q) begin
					re      = 1'b1;
					raddr   = lo_q[AW-1:0];
					state_d = S_REV_RDHI;
				end else begin
					unique case (phase_q)
						RP_FIRST: begin
							lo_d    = s_cw;
							hi_d    = cnt_m1;
							phase_d = RP_SECOND;
						end
						RP_SECOND: begin
							lo_d    = '0;
							hi_d    = cnt_m1;
							phase_d = RP_THIRD;
						end
						RP_THIRD: begin
							phase_d = RP_NONE;
							state_d = S_DONE;
						end
						default: begin
							state_d = S_DONE;
						end
					endcase
				end
			end
			S_REV_RDHI: begin
				tmp_d   = rdata;
				re      = 1'b1;
				raddr   = hi_q[AW-1:0];
				state_d = S_REV_WRLO;
			end
			S_REV_WRLO: begin
				we      = 1'b1;
				waddr   = lo_q[AW-1:0];
				state_d = S_REV_WRHI;
			end
			S_REV_WRHI: begin
				we      = 1'b1;
				waddr   = hi_q[AW-1:0];
				wdata   = tmp_q;
				lo_d    = lo_q + 1'b1;
				hi_d    = hi_q - 1'b1;
				state_d = S_REV_LOOP;
			end
			S_MOD: begin
				if (s_q < 0) begin
					s_d = s_q + n_s;
				end else if (s_q >= n_s) begin
					s_d = s_q - n_s;
				end else if (s_q == '0) begin
					state_d = S_DONE;
				end else begin
					lo_d    = '0;
					hi_d    = s_cw - 1'b1;
					phase_d = RP_FIRST;
					state_d = S_REV_LOOP;
				end
			end
			S_DUP_FIRST: begin
				tmp_d   = rdata;
				w_d     = CW'(1);
				i_d     = CW'(1);
				state_d = S_DUP_LOOP;
			end
			S_DUP_LOOP: begin
				if (i_q < count_q) begin
					re      = 1'b1;
					raddr   = i_q[AW-1:0];
					state_d = S_DUP_CMP;
				end else begin
					count_d = w_q;
					state_d = S_DONE;
				end
			end
			S_DUP_CMP: begin
				if (rdata != tmp_q) begin
					we    = 1'b1;
					waddr = w_q[AW-1:0];
					tmp_d = rdata;
					w_d   = w_q + 1'b1;
				end
				i_d     = i_inc;
				state_d = S_DUP_LOOP;
			end
			S_READ_WAIT: begin
				rdv_d   = rdata;
				state_d = S_DONE;
			end
			S_DONE: begin
				done = 1'b1;
				if (done_ack) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign result.read_value  = rdv_q;
	assign result.list_length = len_ext[4:0];
	assign result.status      = status_q;

endmodule

@@ rtl/array_list_engine.sv @@
// Top level of the array list engine: stream ports and result register.
//
//  channel  dir  handshake          payload
//  s_*      in   s_tvalid/s_tready  tdata value,pos,pos_end,rotate_amount; tuser req_type
//  m_*      out  m_tvalid/m_tready  tdata read_value,list_length; tuser status
//
// Each step of a request uses the single entry memory once. Insert, delete and dedup
// move or compare entries one at a time, reverse swaps pairs, and a rotate first
// reduces its amount by adding or taking off the list length.
// Reset clears the length count; the entries stay undefined until written.
// s_tready is low while a request is in work; a waiting result lets the next transfer
// in but holds the one after it.
module array_list_engine import alst_pkg::*; #(
	parameter int CAPACITY = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // value[31:0], pos[36:32], pos_end[41:37], rotate_amount[47:42]
	input  logic [2:0]  s_tuser,  // req_type[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // read_value[31:0], list_length[36:32], zero[39:37]
	output logic [1:0]  m_tuser   // status[1:0]
);

	request_t req;
	result_t  result;
	logic     ready;
	logic     done;
	logic     done_ack;
	logic     m_tvalid_q;
	result_t  out_q;

	assign req.req_type      = s_tuser;
	assign req.value         = s_tdata[31:0];
	assign req.pos           = s_tdata[36:32];
	assign req.pos_end       = s_tdata[41:37];
	assign req.rotate_amount = s_tdata[47:42];

	assign s_tready = ready;
	assign done_ack = done && (!m_tvalid_q || m_tready);

	alst_ctrl #(
		.CAPACITY(CAPACITY)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (s_tvalid && ready),
		.req      (req),
		.ready    (ready),
		.done     (done),
		.done_ack (done_ack),
		.result   (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (done_ack) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done_ack) begin
			out_q <= result;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {3'b000, out_q.list_length, out_q.read_value};
	assign m_tuser  = out_q.status;

endmodule

@@ test/array_list_engine_test.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for array_list_engine: directed list cases, then random traffic.
module array_list_engine_test;
	import alst_pkg::*;

	localparam int LIST_CAPACITY = 16;
	localparam int QUIET_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 150;
	localparam logic [2:0] REQ_SPARE_6 = 3'd6;
	localparam logic [2:0] REQ_SPARE_7 = 3'd7;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata = '0;  // value[31:0], pos[36:32], pos_end[41:37], rotate_amount[47:42]
	logic [2:0]  s_tuser = '0;  // req_type[2:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;       // read_value[31:0], list_length[36:32], zero[39:37]
	logic [1:0]  m_tuser;       // status[1:0]

	logic [31:0] list_mirror[$];
	result_t     pending_results[$];
	int          idle_pct = 0;
	int          stall_pct = 0;
	int          mismatches = 0;
	int          quiet_cycles = 0;

	array_list_engine #(.CAPACITY(LIST_CAPACITY)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic result_t apply_request(logic [2:0] kind, logic [31:0] val,
			logic [4:0] p, logic [4:0] pe, logic signed [5:0] amt);
		result_t     r;
		int          n;
		int          shift;
		int          lo;
		int          hi;
		logic [31:0] swap;
		logic [31:0] kept[$];
		r = '0;
		r.status = STS_OK;
		n = list_mirror.size();
		case (kind)
			REQ_INSERT: begin
				if (n >= LIST_CAPACITY)
					r.status = STS_FULL;
				else if (p < 1 || p > n + 1)
					r.status = STS_BADPOS;
				else
					list_mirror.insert(p - 1, val);
			end
			REQ_DELETE: begin
				if (p < 1 || p > n)
					r.status = STS_BADPOS;
				else
					list_mirror.delete(p - 1);
			end
			REQ_REVERSE: begin
				if (p < 1 || p > n || pe < 1 || pe > n) begin
					r.status = STS_BADPOS;
				end else begin
					lo = p - 1;
					hi = pe - 1;
					while (lo < hi) begin
						swap = list_mirror[lo];
						list_mirror[lo] = list_mirror[hi];
						list_mirror[hi] = swap;
						lo++;
						hi--;
					end
				end
			end
			REQ_ROTATE: begin
				if (n > 0) begin
					shift = int'(amt) % n;
					if (shift < 0)
						shift += n;
					repeat (shift) list_mirror.push_back(list_mirror.pop_front());
				end
			end
			REQ_DEDUP: begin
				if (n > 1) begin
					kept.push_back(list_mirror[0]);
					for (int i = 1; i < n; i++)
						if (list_mirror[i] != kept[kept.size() - 1])
							kept.push_back(list_mirror[i]);
					list_mirror = kept;
				end
			end
			REQ_READ: begin
				if (p < 1 || p > n)
					r.status = STS_BADPOS;
				else
					r.read_value = list_mirror[p - 1];
			end
			default: ;
		endcase
		r.list_length = 5'(list_mirror.size());
		return r;
	endfunction

	task automatic send_request(input logic [2:0] kind, input logic [31:0] val,
			input logic [4:0] p, input logic [4:0] pe, input logic signed [5:0] amt);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {amt, pe, p, val};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		pending_results.push_back(apply_request(kind, val, p, pe, amt));
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	function automatic logic [31:0] pick_value();
		case ($urandom_range(9))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2, 3, 4, 5: return 32'($urandom_range(3));
			default: return $urandom();
		endcase
	endfunction

	task automatic test_empty_list();
		send_request(REQ_READ, 32'd0, 5'd1, 5'd0, 6'sd0);
		send_request(REQ_ROTATE, 32'd0, 5'd0, 5'd0, 6'sd5);
		send_request(REQ_DEDUP, 32'd0, 5'd0, 5'd0, 6'sd0);
		send_request(REQ_INSERT, 32'hFFFF_FFFF, 5'd0, 5'd0, 6'sd0);
		send_request(REQ_INSERT, 32'd9, 5'd2, 5'd0, 6'sd0);
		send_request(REQ_SPARE_7, 32'hFFFF_FFFF, 5'd31, 5'd31, -6'sd1);
	endtask

	task automatic test_fill_to_capacity();
		logic [31:0] val;
		logic [4:0]  p;
		for (int i = 0; i < LIST_CAPACITY; i++) begin
			if (i < 3)
				val = 32'h8000_0000;
			else if (i < 6)
				val = 32'h7FFF_FFFF;
			else if (i == 6)
				val = 32'hFFFF_FFFF;
			else
				val = 32'(i / 4);
			if (i % 3 == 0)
				p = 5'd1;
			else if (i % 3 == 1)
				p = 5'(i + 1);
			else
				p = 5'((i + 1) / 2);
			send_request(REQ_INSERT, val, p, 5'd0, 6'sd0);
		end
		send_request(REQ_INSERT, 32'd1, 5'd1, 5'd0, 6'sd0);
	endtask

	task automatic test_reshape();
		send_request(REQ_REVERSE, 32'd0, 5'd1, 5'd16, 6'sd0);
		send_request(REQ_REVERSE, 32'd0, 5'd5, 5'd5, 6'sd0);
		send_request(REQ_REVERSE, 32'd0, 5'd0, 5'd3, 6'sd0);
		send_request(REQ_REVERSE, 32'd0, 5'd3, 5'd31, 6'sd0);
		send_request(REQ_ROTATE, 32'd0, 5'd0, 5'd0, 6'sd3);
		send_request(REQ_ROTATE, 32'd0, 5'd0, 5'd0, -6'sd5);
		send_request(REQ_ROTATE, 32'd0, 5'd0, 5'd0, 6'sd16);
		send_request(REQ_DEDUP, 32'd0, 5'd0, 5'd0, 6'sd0);
		send_request(REQ_READ, 32'd0, 5'd1, 5'd0, 6'sd0);
		send_request(REQ_DELETE, 32'd0, 5'd1, 5'd0, 6'sd0);
		send_request(REQ_DELETE, 32'd0, 5'd0, 5'd0, 6'sd0);
	endtask

	task automatic test_random_traffic(input int items, input int idle, input int stall);
		logic [2:0]        kind;
		logic [4:0]        p;
		logic [4:0]        pe;
		logic signed [5:0] amt;
		int                n;
		int                pick;
		bit                growing;
		idle_pct  = idle;
		stall_pct = stall;
		for (int k = 0; k < items; k++) begin
			if (k == items / 2)
				drain_results();
			n       = list_mirror.size();
			growing = ((k / 48) % 2) == 0;
			pick    = $urandom_range(99);
			if (pick < (growing ? 50 : 20))
				kind = REQ_INSERT;
			else if (pick < 62)
				kind = REQ_DELETE;
			else if (pick < 75)
				kind = REQ_READ;
			else if (pick < 85)
				kind = REQ_REVERSE;
			else if (pick < 93)
				kind = REQ_ROTATE;
			else if (pick < 97)
				kind = REQ_DEDUP;
			else
				kind = $urandom_range(1) ? REQ_SPARE_6 : REQ_SPARE_7;
			p   = 5'($urandom_range(31));
			pe  = 5'($urandom_range(31));
			amt = 6'(int'($urandom_range(32)) - 16);
			if ($urandom_range(99) < 85) begin
				if (kind == REQ_INSERT)
					p = 5'($urandom_range(n + 1, 1));
				else
					p = 5'($urandom_range(n > 0 ? n : 1, 1));
				if (kind == REQ_REVERSE)
					pe = 5'($urandom_range(n > 0 ? n : 1, 1));
			end
			send_request(kind, pick_value(), p, pe, amt);
		end
	endtask

	always @(posedge clk)
		m_tready <= ($urandom_range(99) >= stall_pct);

	always @(posedge clk) begin : check_result
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				if (mismatches < 10)
					$display("unexpected result: read_value %h length %0d status %0d",
						m_tdata[31:0], m_tdata[36:32], m_tuser);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				if (m_tdata[31:0] !== want.read_value || m_tdata[36:32] !== want.list_length
						|| m_tuser !== want.status) begin
					if (mismatches < 10)
						$display("mismatch: expected %h/%0d/%0d, got %h/%0d/%0d",
							want.read_value, want.list_length, want.status,
							m_tdata[31:0], m_tdata[36:32], m_tuser);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_list();
		test_fill_to_capacity();
		test_reshape();
		test_random_traffic(420, 0, 0);
		test_random_traffic(420, 86, 0);
		test_random_traffic(420, 0, 86);
		test_random_traffic(390, 31, 31);
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

@@ files.f @@
rtl/alst_pkg.sv
rtl/alst_ctrl.sv
rtl/array_list_engine.sv
test/array_list_engine_test.sv
